### sv/plm_pkg.sv
package plm_pkg;

	localparam int CharW = 8;
	localparam int NumW  = 17;
	localparam int PortW = 16;
	localparam int ProdW = NumW + 4;

	localparam logic [CharW-1:0] CHAR_COMMA = 8'd44;
	localparam logic [CharW-1:0] CHAR_DASH  = 8'd45;
	localparam logic [CharW-1:0] CHAR_SPACE = 8'd32;
	localparam logic [CharW-1:0] CHAR_TAB   = 8'd9;
	localparam logic [CharW-1:0] CHAR_CR    = 8'd13;
	localparam logic [CharW-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CharW-1:0] CHAR_NINE  = 8'd57;

	localparam logic [NumW-1:0]  NUM_SAT  = 17'd65536;
	localparam logic [PortW-1:0] PORT_MAX = 16'hffff;

	typedef struct packed {
		logic [NumW-1:0] num;
		logic            started;
		logic            done;
	} plm_num_t;

	typedef struct packed {
		logic go;
		logic last;
	} plm_step_t;

	function automatic plm_num_t feed_number(logic [CharW-1:0] c, plm_num_t cur);
		plm_num_t          nxt;
		logic [ProdW-1:0]  prod;
		logic              blank;
		logic              digit;
		nxt   = cur;
		blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
		digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		// times ten as two shifts, plus the digit from the low nibble
		prod  = {1'b0, cur.num, 3'b000} + {3'b000, cur.num, 1'b0}
			+ {{(ProdW-4){1'b0}}, c[3:0]};
		if (!cur.done && !(!cur.started && blank)) begin
			if (digit) begin
				nxt.started = 1'b1;
				nxt.num = (prod > {{(ProdW-NumW){1'b0}}, NUM_SAT}) ? NUM_SAT
					: prod[NumW-1:0];
			end else begin
				nxt.done = 1'b1;
			end
		end
		return nxt;
	endfunction

	function automatic logic [PortW-1:0] clamp_port(logic [NumW-1:0] n);
		return n[NumW-1] ? PORT_MAX : n[PortW-1:0];
	endfunction

endpackage

### sv/plm_parse.sv
module plm_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  plm_pkg::plm_step_t    step,
	input  logic [7:0]            list_char,
	input  logic [15:0]           query_port,
	output logic                  port_listed
);
	import plm_pkg::*;

	plm_num_t first_q, second_q;
	logic     seen_dash_q, match_found_q;

	plm_num_t first_n, second_n;
	logic     seen_dash_n, match_found_n;
	logic     hit_now, hit_after;

	function automatic logic entry_hit(plm_num_t f, plm_num_t s, logic dash,
		logic [PortW-1:0] q);
		logic [PortW-1:0] a;
		logic [PortW-1:0] b;
		a = clamp_port(f.num);
		b = clamp_port(s.num);
		if (!dash)
			return f.num == {1'b0, q};
		// either order of bounds
		return ((q >= a) && (q <= b)) || ((q >= b) && (q <= a));
	endfunction

	always_comb begin
		first_n       = first_q;
		second_n      = second_q;
		seen_dash_n   = seen_dash_q;
		match_found_n = match_found_q;
		hit_now       = entry_hit(first_q, second_q, seen_dash_q, query_port);
		if (!match_found_q) begin
			if (list_char == CHAR_COMMA) begin
				if (hit_now)
					match_found_n = 1'b1;
				first_n     = '0;
				second_n    = '0;
				seen_dash_n = 1'b0;
			end else if ((list_char == CHAR_DASH) && !seen_dash_q) begin
				seen_dash_n = 1'b1;
			end else if (seen_dash_q) begin
				second_n = feed_number(list_char, second_q);
			end else begin
				first_n = feed_number(list_char, first_q);
			end
		end
		hit_after   = entry_hit(first_n, second_n, seen_dash_n, query_port);
		port_listed = match_found_n || ((list_char != CHAR_COMMA) && hit_after);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q       <= '0;
			second_q      <= '0;
			seen_dash_q   <= 1'b0;
			match_found_q <= 1'b0;
		end else if (step.go) begin
			if (step.last) begin
				first_q       <= '0;
				second_q      <= '0;
				seen_dash_q   <= 1'b0;
				match_found_q <= 1'b0;
			end else begin
				first_q       <= first_n;
				second_q      <= second_n;
				seen_dash_q   <= seen_dash_n;
				match_found_q <= match_found_n;
			end
		end
	end

endmodule

### sv/port_list_matcher_top.sv
// Port list matcher: takes a comma separated list of ports and port ranges
// (for example "22, 80-443,8080") one ASCII character per request, with
// last_char set on the final character, and returns one request carrying
// port_listed for each list, telling whether query_port is covered. Numbers
// are read like atoi (leading blanks skipped, digits up to the first other
// character, empty means 0); range bounds may be swapped. A character is
// taken every cycle while list_stall is low: it is held in an input register,
// the entry state is updated by one multiply-by-ten add and the range
// compares, and the answer for the final character is written into the
// output register. Only a final character waits in the input
// register, while an earlier answer is still held, and that stalls the
// input. Write query_port over the APB port at address 0 only while no
// list is in flight.
module port_list_matcher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  list_char,
	input  logic        last_char,
	input  logic        list_valid,
	output logic        list_stall,
	output logic        port_listed,
	output logic        result_valid,
	input  logic        result_stall,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import plm_pkg::*;

	logic [PortW-1:0] query_port_q;
	logic [CharW-1:0] char_s1;
	logic             last_s1;
	logic             valid_s1;
	logic             listed_s2;
	logic             valid_s2;
	logic             listed_n;
	logic             proc;
	logic             take;
	plm_step_t        step;

	// apb register
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32-PortW){1'b0}}, query_port_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_port_q <= '0;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			query_port_q <= pwdata[PortW-1:0];
		end
	end

	// a character with a result waits only while the output is full and held
	assign proc       = valid_s1 && (!last_s1 || !valid_s2 || !result_stall);
	assign list_stall = valid_s1 && !proc;
	assign take       = list_valid && !list_stall;
	assign step       = '{go: proc, last: last_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= list_char;
			last_s1 <= last_char;
		end
	end

	plm_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.list_char   (char_s1),
		.query_port  (query_port_q),
		.port_listed (listed_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (proc && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			listed_s2 <= listed_n;
		end
	end

	assign port_listed  = listed_s2;
	assign result_valid = valid_s2;

endmodule

### dv/port_list_checker.sv
module port_list_checker #(
	parameter logic [2:0] QUERY_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  list_char,
	input  logic        last_char,
	input  logic        list_valid,
	input  logic        list_stall,
	input  logic        port_listed,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);
	import plm_pkg::*;

	typedef struct packed {
		logic [NumW-1:0] value;
		logic            begun;
		logic            ended;
	} number_acc_t;

	typedef struct packed {
		number_acc_t num_a;
		number_acc_t num_b;
		logic        dash;
	} entry_acc_t;

	entry_acc_t       cur_entry;
	logic             list_hit;
	logic [PortW-1:0] query;
	logic             expected_listed[$];
	int               fails;

	function automatic logic is_space(logic [CharW-1:0] c);
		return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
	endfunction

	function automatic number_acc_t take_char(logic [CharW-1:0] c, number_acc_t n);
		int unsigned acc;
		if (n.ended || (!n.begun && is_space(c)))
			return n;
		if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
			acc = int'(n.value) * 10 + int'(c - CHAR_ZERO);
			n.begun = 1'b1;
			n.value = (acc > int'(NUM_SAT)) ? NUM_SAT : acc[NumW-1:0];
		end else begin
			n.ended = 1'b1;
		end
		return n;
	endfunction

	function automatic logic entry_covers(entry_acc_t e, logic [PortW-1:0] q);
		logic [NumW-1:0] a;
		logic [NumW-1:0] b;
		logic [NumW-1:0] t;
		if (!e.dash)
			return e.num_a.value == {1'b0, q};
		a = (e.num_a.value > PORT_MAX) ? PORT_MAX : e.num_a.value;
		b = (e.num_b.value > PORT_MAX) ? PORT_MAX : e.num_b.value;
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		return (q >= a) && (q <= b);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			cur_entry = '0;
			list_hit  = 1'b0;
			query     = '0;
			fails     = 0;
			expected_listed.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (list_valid && !list_stall) begin
				if (!list_hit) begin
					if (list_char == CHAR_COMMA) begin
						if (entry_covers(cur_entry, query))
							list_hit = 1'b1;
						cur_entry = '0;
					end else if (list_char == CHAR_DASH && !cur_entry.dash) begin
						cur_entry.dash = 1'b1;
					end else if (cur_entry.dash) begin
						cur_entry.num_b = take_char(list_char, cur_entry.num_b);
					end else begin
						cur_entry.num_a = take_char(list_char, cur_entry.num_a);
					end
				end
				if (last_char) begin
					if (!list_hit && list_char != CHAR_COMMA && entry_covers(cur_entry, query))
						list_hit = 1'b1;
					expected_listed = {expected_listed, list_hit};
					cur_entry = '0;
					list_hit  = 1'b0;
				end
			end
			if (result_valid && !result_stall) begin
				if (expected_listed.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result request, port_listed=%0b",
							$realtime, port_listed);
				end else begin
					want = expected_listed.pop_front();
					if (port_listed !== want) begin
						fails++;
						if (fails <= 10)
							$display("%0t: port_listed mismatch, expected %0b got %0b",
								$realtime, want, port_listed);
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == QUERY_ADDR)
				query = pwdata[PortW-1:0];
			fail_count <= fails;
			pending    <= expected_listed.size();
		end
	end

endmodule

### dv/port_list_matcher_top_tb.sv
module port_list_matcher_top_tb;
	import plm_pkg::*;

	localparam logic [2:0] QUERY_ADDR     = 3'd0;
	localparam int         HOLD_CYCLES    = 300;
	localparam int         WATCHDOG_LIMIT = 5000;
	localparam int         PHASE_CHARS    = 300;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic [7:0]  list_char    = '0;
	logic        last_char    = 1'b0;
	logic        list_valid   = 1'b0;
	logic        list_stall;
	logic        port_listed;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;

	int         send_idle  = 6;
	int         recv_idle  = 72;
	int         sent_chars = 0;
	int         query_now  = 0;
	int         hold_ask   = 0;
	int         hold_seen  = 0;
	int         hold_left  = 0;
	int         quiet      = 0;
	logic [7:0] line_q[$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	port_list_matcher_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.list_char    (list_char),
		.last_char    (last_char),
		.list_valid   (list_valid),
		.list_stall   (list_stall),
		.port_listed  (port_listed),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	port_list_checker #(.QUERY_ADDR(QUERY_ADDR)) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.list_char    (list_char),
		.last_char    (last_char),
		.list_valid   (list_valid),
		.list_stall   (list_stall),
		.port_listed  (port_listed),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// result side: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_seen != hold_ask) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((list_valid && !list_stall) || (result_valid && !result_stall))
			quiet = 0;
		else if (arst_n)
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_char(logic [7:0] c, logic fin);
		bit taken;
		while ($urandom_range(99) < send_idle) begin
			list_valid <= 1'b0;
			@(posedge clk);
		end
		list_char  <= c;
		last_char  <= fin;
		list_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !list_stall;
			@(posedge clk);
		end while (!taken);
		sent_chars++;
	endtask

	task automatic send_list();
		foreach (line_q[i])
			send_char(line_q[i], i == line_q.size() - 1);
		line_q.delete();
	endtask

	task automatic add_char(logic [7:0] c);
		line_q = {line_q, c};
	endtask

	task automatic queue_text(string s);
		foreach (s[i])
			add_char(s[i]);
	endtask

	task automatic wait_drained();
		list_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_query(int v);
		bit rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= QUERY_ADDR;
		pwdata  <= {16'($urandom()), 16'(v)};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel    <= 1'b0;
		penable <= 1'b0;
		query_now = v;
	endtask

	function automatic int pick_number(int q);
		int d;
		d = int'($urandom_range(4)) - 2;
		case ($urandom_range(7))
			0, 1: return q;
			2: return (q + d < 0) ? 0 : q + d;
			3: return int'($urandom_range(99));
			4: return int'($urandom_range(65535));
			5: return int'($urandom_range(999999, 65536));
			6: return -1;
			default: return int'($urandom_range(9));
		endcase
	endfunction

	task automatic push_number(int v);
		string digits;
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(2, 1))
				add_char($urandom_range(1) ? CHAR_SPACE : 8'($urandom_range(13, 9)));
		if (v < 0)
			return;
		if ($urandom_range(7) == 0)
			add_char(CHAR_ZERO);
		digits = $sformatf("%0d", v);
		foreach (digits[i])
			add_char(digits[i]);
		if ($urandom_range(7) == 0)
			add_char(CHAR_SPACE);
	endtask

	task automatic build_list();
		int n_entries;
		line_q.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(12, 1))
				add_char(8'($urandom_range(255)));
			return;
		end
		n_entries = $urandom_range(4, 1);
		for (int i = 0; i < n_entries; i++) begin
			if (i > 0)
				add_char(CHAR_COMMA);
			push_number(pick_number(query_now));
			if ($urandom_range(2) == 0) begin
				add_char(CHAR_DASH);
				push_number(pick_number(query_now));
				if ($urandom_range(9) == 0) begin
					add_char(CHAR_DASH);
					push_number(pick_number(query_now));
				end
			end
		end
		if ($urandom_range(7) == 0)
			add_char(CHAR_COMMA);
		// broken list: one character swapped for noise
		if (($urandom_range(9) == 0) && (line_q.size() > 0))
			line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
		if (line_q.size() == 0)
			add_char(CHAR_COMMA);
	endtask

	initial begin
		int target;
		int lists;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// query at reset value 0: empty leading entry, trailing comma, extreme bytes
		queue_text(",5");
		send_list();
		queue_text("3,");
		send_list();
		add_char(8'h00);
		add_char(8'hff);
		send_list();

		wait_drained();
		write_query(65535);
		queue_text("99999");
		send_list();
		queue_text("1-99999");
		send_list();
		queue_text("6-5-");
		send_list();

		wait_drained();
		write_query(80);
		queue_text(" \t80");
		send_list();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 6;
					recv_idle = 72;
				end
				1: begin
					send_idle = 72;
					recv_idle = 6;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			target = sent_chars + PHASE_CHARS;
			lists = 0;
			while (sent_chars < target) begin
				if (lists % 8 == 0) begin
					wait_drained();
					case ($urandom_range(3))
						0: write_query(0);
						1: write_query(65535);
						2: write_query($urandom_range(100));
						default: write_query($urandom_range(65535));
					endcase
				end
				// receiver holds off while short lists keep coming
				if (ph == 2 && lists == 4) begin
					hold_ask++;
					repeat (16) begin
						add_char(8'(CHAR_ZERO + $urandom_range(9)));
						send_list();
					end
				end
				build_list();
				send_list();
				lists++;
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
